### hdl/bmrfs_pkg.sv
// Shared types and constants for the two-level bitmap range find-first-set block.
`default_nettype none

package bmrfs_pkg;

   // Field widths fixed by the request and response formats.
   localparam int VALUE_W  = 16;
   localparam int OPCODE_W = 2;

   // Word index and group index widths; words hold at least eight values.
   localparam int IDX_W = VALUE_W - 3;
   // Bit position inside a word, and word position inside a group (both below 64).
   localparam int BIT_W = 6;
   localparam int OFF_W = 6;

   // Request opcodes.
   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

   // Command kinds handed from the front end to the walker.
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MISS   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

   // Command queue depth.
   localparam int QPTR_W      = 1;
   localparam int QUEUE_DEPTH = 1 << QPTR_W;

   // One decoded command: word and bit positions of both bounds, plus group data.
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [IDX_W-1:0]   lw;
      logic [IDX_W-1:0]   rw;
      logic [BIT_W-1:0]   lo_bit;
      logic [BIT_W-1:0]   hi_bit;
      logic [IDX_W-1:0]   grp;
      logic [OFF_W-1:0]   off;
      logic [VALUE_W-1:0] base;
   } cmd_type;

endpackage

`default_nettype wire

### hdl/bmrfs_front.sv
// Front end: accepts request beats, clamps bounds and splits values into word and bit positions.
`default_nettype none

module bmrfs_front #(
   parameter int VALUE_COUNT     = 65536,
   parameter int WORD_WIDTH      = 64,
   parameter int WORDS_PER_GROUP = 4
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                accept_en,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic [bmrfs_pkg::OPCODE_W-1:0]      req_opcode,
   input  wire logic [bmrfs_pkg::VALUE_W-1:0]       req_low_value,
   input  wire logic [bmrfs_pkg::VALUE_W-1:0]       req_high_value,
   output      logic                                cmd_valid,
   input  wire logic                                cmd_ready,
   output      bmrfs_pkg::cmd_type                  cmd
);

   localparam int LAST_VALUE = VALUE_COUNT - 1;

   // Reciprocal constants; the shift is wide enough that the quotient is exact.
   localparam int WSH = bmrfs_pkg::VALUE_W + 2 * ($clog2(WORD_WIDTH) + 1);
   localparam longint unsigned WMUL =
      ((64'd1 << WSH) + 64'(WORD_WIDTH) - 64'd1) / 64'(WORD_WIDTH);
   localparam int WPROD_W = bmrfs_pkg::VALUE_W + WSH + 1;

   localparam int GSH = bmrfs_pkg::IDX_W + 2 * ($clog2(WORDS_PER_GROUP) + 1);
   localparam longint unsigned GMUL =
      ((64'd1 << GSH) + 64'(WORDS_PER_GROUP) - 64'd1) / 64'(WORDS_PER_GROUP);
   localparam int GPROD_W = bmrfs_pkg::IDX_W + GSH + 1;

   logic                               adv;
   logic [bmrfs_pkg::VALUE_W-1:0]      lo_clamp;
   logic [bmrfs_pkg::VALUE_W-1:0]      hi_clamp;

   logic                               s1_valid_in, s1_valid_ff;
   logic [bmrfs_pkg::KIND_W-1:0]       s1_kind_in, s1_kind_ff;
   logic [bmrfs_pkg::VALUE_W-1:0]      s1_x_in, s1_x_ff;
   logic [bmrfs_pkg::VALUE_W-1:0]      s1_hi_ff;

   logic [WPROD_W-1:0]                 prod_lo;
   logic [WPROD_W-1:0]                 prod_hi;
   logic                               s2_valid_ff;
   logic [bmrfs_pkg::KIND_W-1:0]       s2_kind_ff;
   logic [bmrfs_pkg::VALUE_W-1:0]      s2_x_ff;
   logic [bmrfs_pkg::VALUE_W-1:0]      s2_hi_ff;
   logic [bmrfs_pkg::IDX_W-1:0]        s2_q_lo_in, s2_q_lo_ff;
   logic [bmrfs_pkg::IDX_W-1:0]        s2_q_hi_in, s2_q_hi_ff;

   logic [bmrfs_pkg::VALUE_W-1:0]      lo_base;
   logic [bmrfs_pkg::VALUE_W-1:0]      hi_base;
   logic [GPROD_W-1:0]                 prod_g;
   logic                               s3_valid_ff;
   logic [bmrfs_pkg::KIND_W-1:0]       s3_kind_ff;
   logic [bmrfs_pkg::IDX_W-1:0]        s3_lw_ff;
   logic [bmrfs_pkg::IDX_W-1:0]        s3_rw_ff;
   logic [bmrfs_pkg::BIT_W-1:0]        s3_lo_bit_in, s3_lo_bit_ff;
   logic [bmrfs_pkg::BIT_W-1:0]        s3_hi_bit_in, s3_hi_bit_ff;
   logic [bmrfs_pkg::VALUE_W-1:0]      s3_base_ff;
   logic [bmrfs_pkg::IDX_W-1:0]        s3_grp_in, s3_grp_ff;

   // The whole pipeline advances unless the last stage holds a command the queue refuses.
   assign adv       = !s3_valid_ff || cmd_ready;
   assign req_ready = adv && accept_en;

   // Stage one: clamp the bounds and classify the beat.
   always_comb begin
      lo_clamp    = (req_low_value == '0) ? bmrfs_pkg::VALUE_W'(1) : req_low_value;
      hi_clamp    = (32'(req_high_value) > LAST_VALUE) ?
                    bmrfs_pkg::VALUE_W'(LAST_VALUE) : req_high_value;
      s1_valid_in = 1'b0;
      s1_kind_in  = bmrfs_pkg::KIND_INSERT;
      s1_x_in     = req_low_value;
      case (req_opcode)
         bmrfs_pkg::OP_INSERT: begin
            s1_valid_in = 32'(req_low_value) < VALUE_COUNT;
         end
         bmrfs_pkg::OP_QUERY: begin
            s1_valid_in = 1'b1;
            s1_x_in     = lo_clamp;
            s1_kind_in  = (lo_clamp > hi_clamp) ? bmrfs_pkg::KIND_MISS : bmrfs_pkg::KIND_QUERY;
         end
         bmrfs_pkg::OP_CLEAR: begin
            s1_valid_in = 1'b1;
            s1_kind_in  = bmrfs_pkg::KIND_CLEAR;
         end
         default: begin
            s1_valid_in = 1'b0;
         end
      endcase
      s1_valid_in = s1_valid_in && req_valid && req_ready;
   end

   // Stage two: word index of both bounds through a reciprocal multiply.
   always_comb begin
      prod_lo    = WPROD_W'(s1_x_ff) * WPROD_W'(WMUL);
      prod_hi    = WPROD_W'(s1_hi_ff) * WPROD_W'(WMUL);
      s2_q_lo_in = bmrfs_pkg::IDX_W'(prod_lo >> WSH);
      s2_q_hi_in = bmrfs_pkg::IDX_W'(prod_hi >> WSH);
   end

   // Stage three: bit positions, word base value and group index.
   always_comb begin
      lo_base      = bmrfs_pkg::VALUE_W'(32'(s2_q_lo_ff) * 32'(WORD_WIDTH));
      hi_base      = bmrfs_pkg::VALUE_W'(32'(s2_q_hi_ff) * 32'(WORD_WIDTH));
      s3_lo_bit_in = bmrfs_pkg::BIT_W'(s2_x_ff - lo_base);
      s3_hi_bit_in = bmrfs_pkg::BIT_W'(s2_hi_ff - hi_base);
      prod_g       = GPROD_W'(s2_q_lo_ff) * GPROD_W'(GMUL);
      s3_grp_in    = bmrfs_pkg::IDX_W'(prod_g >> GSH);
   end

   // Command to the queue; the word's place within its group is the last remainder.
   always_comb begin
      cmd.kind   = s3_kind_ff;
      cmd.lw     = s3_lw_ff;
      cmd.rw     = s3_rw_ff;
      cmd.lo_bit = s3_lo_bit_ff;
      cmd.hi_bit = s3_hi_bit_ff;
      cmd.grp    = s3_grp_ff;
      cmd.base   = s3_base_ff;
      cmd.off    = bmrfs_pkg::OFF_W'(s3_lw_ff - bmrfs_pkg::IDX_W'(
                      32'(s3_grp_ff) * 32'(WORDS_PER_GROUP)));
   end

   assign cmd_valid = s3_valid_ff;

   // Stage valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_kind_ff   <= s1_kind_in;
         s1_x_ff      <= s1_x_in;
         s1_hi_ff     <= hi_clamp;
         s2_kind_ff   <= s1_kind_ff;
         s2_x_ff      <= s1_x_ff;
         s2_hi_ff     <= s1_hi_ff;
         s2_q_lo_ff   <= s2_q_lo_in;
         s2_q_hi_ff   <= s2_q_hi_in;
         s3_kind_ff   <= s2_kind_ff;
         s3_lw_ff     <= s2_q_lo_ff;
         s3_rw_ff     <= s2_q_hi_ff;
         s3_lo_bit_ff <= s3_lo_bit_in;
         s3_hi_bit_ff <= s3_hi_bit_in;
         s3_base_ff   <= lo_base;
         s3_grp_ff    <= s3_grp_in;
      end
   end

endmodule

`default_nettype wire

### hdl/bmrfs_fifo.sv
// Short command queue between the front end and the walker.
`default_nettype none

module bmrfs_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output      logic               in_ready,
   input  wire bmrfs_pkg::cmd_type in_data,
   output      logic               out_valid,
   input  wire logic               out_ready,
   output      bmrfs_pkg::cmd_type out_data
);

   bmrfs_pkg::cmd_type              entry_ff [bmrfs_pkg::QUEUE_DEPTH];
   logic [bmrfs_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [bmrfs_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [bmrfs_pkg::QPTR_W:0]      count_ff, count_in;
   logic                            push;
   logic                            pop;

   assign in_ready  = count_ff < (bmrfs_pkg::QPTR_W + 1)'(bmrfs_pkg::QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointers wrap naturally since the depth is a power of two.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (bmrfs_pkg::QPTR_W + 1)'(push) - (bmrfs_pkg::QPTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

### hdl/bmrfs_walk.sv
// Walker: owns the presence and group memories and carries out insert, query and clear.
`default_nettype none

module bmrfs_walk #(
   parameter int VALUE_COUNT     = 65536,
   parameter int WORD_WIDTH      = 64,
   parameter int WORDS_PER_GROUP = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   output      logic                          init_done,
   input  wire logic                          cmd_valid,
   output      logic                          cmd_ready,
   input  wire bmrfs_pkg::cmd_type            cmd,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic                          rsp_found,
   output      logic [bmrfs_pkg::VALUE_W-1:0] rsp_first_value
);

   localparam int WORD_COUNT  = (VALUE_COUNT + WORD_WIDTH - 1) / WORD_WIDTH;
   localparam int GROUP_COUNT = (WORD_COUNT + WORDS_PER_GROUP - 1) / WORDS_PER_GROUP;
   localparam int WA_W        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int GA_W        = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
   localparam int GROUP_SPAN  = WORDS_PER_GROUP * WORD_WIDTH;
   localparam logic [WORD_WIDTH-1:0] FULL_WORD = {WORD_WIDTH{1'b1}};
   localparam logic [WORD_WIDTH-1:0] ONE_WORD  = WORD_WIDTH'(1);

   localparam int ST_W = 2;
   localparam logic [ST_W-1:0] ST_CLEAR  = 2'd0;
   localparam logic [ST_W-1:0] ST_IDLE   = 2'd1;
   localparam logic [ST_W-1:0] ST_INS_WR = 2'd2;
   localparam logic [ST_W-1:0] ST_QUERY  = 2'd3;

   // Memories.
   logic [WORD_WIDTH-1:0]            word_mem [WORD_COUNT];
   logic                             grp_mem  [GROUP_COUNT];
   logic [WORD_WIDTH-1:0]            word_rd_ff;
   logic                             grp_rd_ff;

   logic                             word_we;
   logic [WA_W-1:0]                  word_wa;
   logic [WORD_WIDTH-1:0]            word_wd;
   logic                             grp_we;
   logic [GA_W-1:0]                  grp_wa;
   logic                             grp_wd;
   logic [WA_W-1:0]                  rd_word_addr;
   logic [GA_W-1:0]                  rd_grp_addr;

   // Control state.
   logic [ST_W-1:0]                  state_ff, state_in;
   logic [WA_W-1:0]                  sweep_ff, sweep_in;
   logic                             init_ff, init_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   // Walk context.
   logic [bmrfs_pkg::IDX_W-1:0]      w_ff, w_in;
   logic [bmrfs_pkg::IDX_W-1:0]      rw_ff, rw_in;
   logic [bmrfs_pkg::OFF_W-1:0]      off_ff, off_in;
   logic [bmrfs_pkg::IDX_W-1:0]      gi_ff, gi_in;
   logic [bmrfs_pkg::VALUE_W-1:0]    base_ff, base_in;
   logic [bmrfs_pkg::BIT_W-1:0]      lo_bit_ff, lo_bit_in;
   logic [bmrfs_pkg::BIT_W-1:0]      hi_bit_ff, hi_bit_in;
   logic                             first_ff, first_in;
   logic                             rsp_found_ff, rsp_found_in;
   logic [bmrfs_pkg::VALUE_W-1:0]    rsp_value_ff, rsp_value_in;

   // Query evaluation.
   logic                             rsp_free;
   logic                             rsp_load;
   logic                             last_word;
   logic [bmrfs_pkg::IDX_W:0]        span_end;
   logic                             skip;
   logic [WORD_WIDTH-1:0]            lo_mask;
   logic [WORD_WIDTH-1:0]            hi_mask;
   logic [WORD_WIDTH-1:0]            masked;
   logic                             hit;
   logic                             done;
   logic [bmrfs_pkg::BIT_W-1:0]      pos;
   logic                             off_last;

   assign init_done       = !init_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_first_value = rsp_value_ff;
   assign rsp_free        = !rsp_valid_ff || rsp_ready;

   // Current word: masking of the edge words, group skip test and lowest set bit.
   always_comb begin
      last_word = (w_ff == rw_ff);
      span_end  = (bmrfs_pkg::IDX_W + 1)'(w_ff) + (bmrfs_pkg::IDX_W + 1)'(WORDS_PER_GROUP - 1);
      skip      = !first_ff && (off_ff == '0) &&
                  (span_end < (bmrfs_pkg::IDX_W + 1)'(rw_ff)) && !grp_rd_ff;
      lo_mask   = first_ff ? (FULL_WORD << lo_bit_ff) : FULL_WORD;
      hi_mask   = last_word ?
                  (FULL_WORD >> (bmrfs_pkg::BIT_W'(WORD_WIDTH - 1) - hi_bit_ff)) : FULL_WORD;
      masked    = word_rd_ff & lo_mask & hi_mask;
      hit       = !skip && (masked != '0);
      done      = hit || (!skip && last_word);
      off_last  = (off_ff == bmrfs_pkg::OFF_W'(WORDS_PER_GROUP - 1));
      pos       = '0;
      for (int i = WORD_WIDTH - 1; i >= 0; i--) begin
         if (masked[i]) begin
            pos = bmrfs_pkg::BIT_W'(i);
         end
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      init_in      = init_ff;
      w_in         = w_ff;
      rw_in        = rw_ff;
      off_in       = off_ff;
      gi_in        = gi_ff;
      base_in      = base_ff;
      lo_bit_in    = lo_bit_ff;
      hi_bit_in    = hi_bit_ff;
      first_in     = first_ff;
      rsp_found_in = rsp_found_ff;
      rsp_value_in = rsp_value_ff;
      rsp_load     = 1'b0;
      cmd_ready    = 1'b0;
      word_we      = 1'b0;
      word_wa      = WA_W'(w_ff);
      word_wd      = word_rd_ff | (ONE_WORD << lo_bit_ff);
      grp_we       = 1'b0;
      grp_wa       = GA_W'(gi_ff);
      grp_wd       = 1'b1;
      rd_word_addr = WA_W'(w_ff);
      rd_grp_addr  = GA_W'(gi_ff);
      case (state_ff)
         ST_CLEAR: begin
            // One word cleared per cycle, plus the group bit of the same index while one exists.
            word_we = 1'b1;
            word_wa = sweep_ff;
            word_wd = '0;
            grp_we  = 32'(sweep_ff) < GROUP_COUNT;
            grp_wa  = GA_W'(sweep_ff);
            grp_wd  = 1'b0;
            if (sweep_ff == WA_W'(WORD_COUNT - 1)) begin
               state_in = ST_IDLE;
               init_in  = 1'b0;
               sweep_in = '0;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            // Start the read of the head command's first word right away.
            rd_word_addr = WA_W'(cmd.lw);
            rd_grp_addr  = GA_W'(cmd.grp);
            if (cmd_valid) begin
               case (cmd.kind)
                  bmrfs_pkg::KIND_INSERT: begin
                     cmd_ready = 1'b1;
                     w_in      = cmd.lw;
                     gi_in     = cmd.grp;
                     lo_bit_in = cmd.lo_bit;
                     state_in  = ST_INS_WR;
                  end
                  bmrfs_pkg::KIND_QUERY: begin
                     cmd_ready = 1'b1;
                     w_in      = cmd.lw;
                     rw_in     = cmd.rw;
                     gi_in     = cmd.grp;
                     off_in    = cmd.off;
                     base_in   = cmd.base;
                     lo_bit_in = cmd.lo_bit;
                     hi_bit_in = cmd.hi_bit;
                     first_in  = 1'b1;
                     state_in  = ST_QUERY;
                  end
                  bmrfs_pkg::KIND_MISS: begin
                     if (rsp_free) begin
                        cmd_ready    = 1'b1;
                        rsp_load     = 1'b1;
                        rsp_found_in = 1'b0;
                        rsp_value_in = '0;
                     end
                  end
                  bmrfs_pkg::KIND_CLEAR: begin
                     cmd_ready = 1'b1;
                     sweep_in  = '0;
                     state_in  = ST_CLEAR;
                  end
                  default: begin
                     cmd_ready = 1'b0;
                  end
               endcase
            end
         end
         ST_INS_WR: begin
            // Read-modify-write of the word, and mark its group nonempty.
            word_we  = 1'b1;
            grp_we   = 1'b1;
            state_in = ST_IDLE;
         end
         ST_QUERY: begin
            if (done) begin
               if (rsp_free) begin
                  rsp_load     = 1'b1;
                  rsp_found_in = hit;
                  rsp_value_in = hit ? base_ff + bmrfs_pkg::VALUE_W'(pos) : '0;
                  state_in     = ST_IDLE;
               end
            end else if (skip) begin
               // Whole empty group inside the range.
               w_in     = w_ff + bmrfs_pkg::IDX_W'(WORDS_PER_GROUP);
               gi_in    = gi_ff + 1'b1;
               base_in  = base_ff + bmrfs_pkg::VALUE_W'(GROUP_SPAN);
               first_in = 1'b0;
            end else begin
               w_in     = w_ff + 1'b1;
               off_in   = off_last ? '0 : off_ff + 1'b1;
               gi_in    = off_last ? gi_ff + 1'b1 : gi_ff;
               base_in  = base_ff + bmrfs_pkg::VALUE_W'(WORD_WIDTH);
               first_in = 1'b0;
            end
            rd_word_addr = WA_W'(w_in);
            rd_grp_addr  = GA_W'(gi_in);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk context and response payload.
   always_ff @(posedge clock) begin
      w_ff         <= w_in;
      rw_ff        <= rw_in;
      off_ff       <= off_in;
      gi_ff        <= gi_in;
      base_ff      <= base_in;
      lo_bit_ff    <= lo_bit_in;
      hi_bit_ff    <= hi_bit_in;
      first_ff     <= first_in;
      rsp_found_ff <= rsp_found_in;
      rsp_value_ff <= rsp_value_in;
   end

   // Presence word memory with registered read.
   always_ff @(posedge clock) begin
      if (word_we) begin
         word_mem[word_wa] <= word_wd;
      end
      word_rd_ff <= word_mem[rd_word_addr];
   end

   // Group summary memory with registered read.
   always_ff @(posedge clock) begin
      if (grp_we) begin
         grp_mem[grp_wa] <= grp_wd;
      end
      grp_rd_ff <= grp_mem[rd_grp_addr];
   end

endmodule

`default_nettype wire

### hdl/bitmap_range_first_set_top.sv
// Top level of the two-level bitmap range find-first-set block.
//
// Request channel (req_): opcode 0 inserts req_low_value, opcode 1 asks for the
// smallest present value in [req_low_value, req_high_value] (low raised to 1, high
// lowered to the top value), opcode 2 clears every value. Opcode 3 is dropped.
// Response channel (rsp_): one beat per query with rsp_found and rsp_first_value.
// A three-stage front end decodes each beat into word and bit positions and hands
// it through a two-entry queue to the walker, which owns the memories.
// An insert reads the word, then writes it back with the new bit set. A query
// starts the read of its first word, then reads the range word by word and skips
// empty groups that lie wholly inside it. A clear sweeps the memories at one word
// per cycle through all WORD_COUNT words (1024 by default). An empty range answers
// without reading the memories. After reset the same sweep runs first and
// req_ready stays low until it ends. A waiting response sits in an output
// register; the walker keeps working until it has a second response to give, and
// the front end keeps accepting until the queue and its pipeline are full.
`default_nettype none

module bitmap_range_first_set_top #(
   parameter int VALUE_COUNT     = 65536,
   parameter int WORD_WIDTH      = 64,
   parameter int WORDS_PER_GROUP = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic [bmrfs_pkg::OPCODE_W-1:0]    req_opcode,
   input  wire logic [bmrfs_pkg::VALUE_W-1:0]     req_low_value,
   input  wire logic [bmrfs_pkg::VALUE_W-1:0]     req_high_value,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic                              rsp_found,
   output      logic [bmrfs_pkg::VALUE_W-1:0]     rsp_first_value
);

   logic               init_done;
   logic               front_valid;
   logic               front_ready;
   bmrfs_pkg::cmd_type front_cmd;
   logic               head_valid;
   logic               head_ready;
   bmrfs_pkg::cmd_type head_cmd;

   // Decode and classify request beats.
   bmrfs_front #(
      .VALUE_COUNT     (VALUE_COUNT),
      .WORD_WIDTH      (WORD_WIDTH),
      .WORDS_PER_GROUP (WORDS_PER_GROUP)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept_en      (init_done),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_low_value  (req_low_value),
      .req_high_value (req_high_value),
      .cmd_valid      (front_valid),
      .cmd_ready      (front_ready),
      .cmd            (front_cmd)
   );

   // Command queue.
   bmrfs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_cmd),
      .out_valid (head_valid),
      .out_ready (head_ready),
      .out_data  (head_cmd)
   );

   // Memory walker and response register.
   bmrfs_walk #(
      .VALUE_COUNT     (VALUE_COUNT),
      .WORD_WIDTH      (WORD_WIDTH),
      .WORDS_PER_GROUP (WORDS_PER_GROUP)
   ) u_walk (
      .clock           (clock),
      .reset           (reset),
      .init_done       (init_done),
      .cmd_valid       (head_valid),
      .cmd_ready       (head_ready),
      .cmd             (head_cmd),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_first_value (rsp_first_value)
   );

endmodule

`default_nettype wire

### hdl/bmrfs_checker.sv
// Port-level assertions for the bitmap range find-first-set block, with its bind.
`default_nettype none

module bmrfs_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic [bmrfs_pkg::OPCODE_W-1:0]    req_opcode,
   input wire logic [bmrfs_pkg::VALUE_W-1:0]     req_low_value,
   input wire logic [bmrfs_pkg::VALUE_W-1:0]     req_high_value,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic                              rsp_found,
   input wire logic [bmrfs_pkg::VALUE_W-1:0]     rsp_first_value
);

   // A waiting request beat holds its payload until it is taken.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_opcode) &&
                                  $stable(req_low_value) && $stable(req_high_value))
      else $error("request beat changed while waiting");

   // A stalled response beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_first_value))
      else $error("response beat changed while stalled");

   // A miss always reports value zero.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_first_value == '0)
      else $error("miss reported a nonzero value");

   // The low bound is raised to one, so a hit is never value zero.
   a_hit_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_first_value != '0)
      else $error("hit reported value zero");

   // Reset empties the response register and starts the clearing sweep.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("block active right after reset");

endmodule

bind bitmap_range_first_set_top bmrfs_checker u_bmrfs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_opcode      (req_opcode),
   .req_low_value   (req_low_value),
   .req_high_value  (req_high_value),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_found       (rsp_found),
   .rsp_first_value (rsp_first_value)
);

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the two-level bitmap range find-first-set block.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Block geometry, kept equal to the parameters given to the instance.
   localparam int VALUE_TOTAL   = 65536;
   localparam int BITS_PER_WORD = 64;
   localparam int GROUP_WORDS   = 4;
   localparam int WORD_TOTAL    = VALUE_TOTAL / BITS_PER_WORD;
   localparam int TOP_VALUE     = VALUE_TOTAL - 1;
   localparam int WIDX_W        = $clog2(WORD_TOTAL);
   localparam int BPOS_W        = $clog2(BITS_PER_WORD);

   // The opcode that the block drops.
   localparam logic [bmrfs_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

   localparam int          RESET_CYCLES = 12;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          DRAIN_CYCLES = 2200;
   localparam int unsigned CYCLE_LIMIT  = 2000000;

   typedef struct packed {
      logic                          found;
      logic [bmrfs_pkg::VALUE_W-1:0] first_value;
   } query_answer_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [bmrfs_pkg::OPCODE_W-1:0] req_opcode = bmrfs_pkg::OP_INSERT;
   logic [bmrfs_pkg::VALUE_W-1:0]  req_low_value = '0;
   logic [bmrfs_pkg::VALUE_W-1:0]  req_high_value = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic                           rsp_found;
   logic [bmrfs_pkg::VALUE_W-1:0]  rsp_first_value;

   // Mirror of the presence bitmap and the answers still owed by the block.
   logic [BITS_PER_WORD-1:0] bitmap_words [WORD_TOTAL];
   query_answer_type         owed_answers [$];

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned hold_asked    = 0;
   int unsigned hold_done     = 0;
   int unsigned hold_left     = 0;
   int unsigned fail_count    = 0;
   int unsigned cycle_count   = 0;
   int unsigned hot_base      = 0;

   bitmap_range_first_set_top #(
      .VALUE_COUNT    (VALUE_TOTAL),
      .WORD_WIDTH     (BITS_PER_WORD),
      .WORDS_PER_GROUP(GROUP_WORDS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_low_value  (req_low_value),
      .req_high_value (req_high_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_first_value(rsp_first_value)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Smallest present value in the clamped range, found by walking the words.
   function automatic query_answer_type first_in_range(logic [bmrfs_pkg::VALUE_W-1:0] low_v,
                                                       logic [bmrfs_pkg::VALUE_W-1:0] high_v);
      query_answer_type         ans;
      int unsigned              lo;
      int unsigned              hi;
      int unsigned              w;
      int unsigned              pos;
      logic [BITS_PER_WORD-1:0] m;
      ans = '0;
      lo  = (low_v == 0) ? 1 : low_v;
      hi  = (high_v > TOP_VALUE) ? TOP_VALUE : high_v;
      if (lo > hi) return ans;
      for (w = lo / BITS_PER_WORD; w <= hi / BITS_PER_WORD; w++) begin
         m = bitmap_words[WIDX_W'(w)];
         if (w == lo / BITS_PER_WORD) m &= {BITS_PER_WORD{1'b1}} << (lo % BITS_PER_WORD);
         if (w == hi / BITS_PER_WORD)
            m &= {BITS_PER_WORD{1'b1}} >> (BITS_PER_WORD - 1 - hi % BITS_PER_WORD);
         if (m != 0) begin
            for (pos = 0; pos < BITS_PER_WORD; pos++) begin
               if (m[BPOS_W'(pos)]) begin
                  ans.found       = 1'b1;
                  ans.first_value = bmrfs_pkg::VALUE_W'(w * BITS_PER_WORD + pos);
                  return ans;
               end
            end
         end
      end
      return ans;
   endfunction

   // Offer one beat, wait for it to be taken, update the mirror, then idle at random.
   task automatic send_item(input logic [bmrfs_pkg::OPCODE_W-1:0] op,
                            input logic [bmrfs_pkg::VALUE_W-1:0]  low_v,
                            input logic [bmrfs_pkg::VALUE_W-1:0]  high_v);
      int unsigned gap;
      gap = 0;
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_low_value  <= low_v;
      req_high_value <= high_v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      case (op)
         bmrfs_pkg::OP_INSERT: begin
            if (low_v < VALUE_TOTAL)
               bitmap_words[WIDX_W'(low_v / BITS_PER_WORD)]
                           [BPOS_W'(low_v % BITS_PER_WORD)] = 1'b1;
         end
         bmrfs_pkg::OP_QUERY: owed_answers.push_back(first_in_range(low_v, high_v));
         bmrfs_pkg::OP_CLEAR: begin
            foreach (bitmap_words[i]) bitmap_words[i] = '0;
         end
         default: ;
      endcase
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Insert values lean toward a hot window so that queries find something.
   function automatic logic [bmrfs_pkg::VALUE_W-1:0] pick_insert_value();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 55) return bmrfs_pkg::VALUE_W'(hot_base + $urandom_range(2047));
      if (pick < 60)
         return bmrfs_pkg::VALUE_W'(($urandom_range(1) != 0) ? TOP_VALUE
                                                             : $urandom_range(BITS_PER_WORD));
      return bmrfs_pkg::VALUE_W'($urandom_range(TOP_VALUE));
   endfunction

   // Mostly short ranges, some medium, a few spanning everything, some inverted.
   task automatic pick_query(output logic [bmrfs_pkg::VALUE_W-1:0] low_v,
                             output logic [bmrfs_pkg::VALUE_W-1:0] high_v);
      int unsigned pick;
      int unsigned lo;
      int unsigned hi;
      pick = $urandom_range(99);
      if (pick < 70) begin
         lo = ($urandom_range(99) < 60) ? hot_base + $urandom_range(2047)
                                        : $urandom_range(TOP_VALUE);
         hi = lo + $urandom_range(700);
      end else if (pick < 85) begin
         lo = $urandom_range(TOP_VALUE);
         hi = lo + $urandom_range(8192);
      end else if (pick < 89) begin
         lo = $urandom_range(2);
         hi = $urandom_range(TOP_VALUE, TOP_VALUE - 500);
      end else if (pick < 95) begin
         hi = $urandom_range(TOP_VALUE - 1);
         lo = hi + $urandom_range(300, 1);
      end else begin
         lo = $urandom_range(TOP_VALUE);
         hi = $urandom_range(TOP_VALUE);
      end
      low_v  = bmrfs_pkg::VALUE_W'((lo > TOP_VALUE) ? TOP_VALUE : lo);
      high_v = bmrfs_pkg::VALUE_W'((hi > TOP_VALUE) ? TOP_VALUE : hi);
   endtask

   // Extremes of the fields, word edges, value zero, empty and inverted ranges.
   task automatic test_directed_edges();
      send_item(bmrfs_pkg::OP_QUERY,  16'd0,     16'hFFFF);
      send_item(bmrfs_pkg::OP_INSERT, 16'd0,     16'hFFFF);
      send_item(bmrfs_pkg::OP_QUERY,  16'd0,     16'd0);
      send_item(bmrfs_pkg::OP_QUERY,  16'd0,     16'd10);
      send_item(bmrfs_pkg::OP_INSERT, 16'hFFFF,  16'd0);
      send_item(bmrfs_pkg::OP_QUERY,  16'hFFFF,  16'hFFFF);
      send_item(bmrfs_pkg::OP_QUERY,  16'd1,     16'hFFFF);
      send_item(bmrfs_pkg::OP_INSERT, 16'd1,     16'h5555);
      send_item(bmrfs_pkg::OP_QUERY,  16'd0,     16'hFFFF);
      send_item(bmrfs_pkg::OP_INSERT, 16'd63,    16'hAAAA);
      send_item(bmrfs_pkg::OP_INSERT, 16'd64,    16'd0);
      send_item(bmrfs_pkg::OP_INSERT, 16'd127,   16'd0);
      send_item(bmrfs_pkg::OP_INSERT, 16'd4352,  16'd0);
      send_item(bmrfs_pkg::OP_QUERY,  16'd2,     16'd63);
      send_item(bmrfs_pkg::OP_QUERY,  16'd64,    16'd64);
      send_item(bmrfs_pkg::OP_QUERY,  16'd65,    16'd200);
      send_item(bmrfs_pkg::OP_QUERY,  16'd128,   16'd60000);
      send_item(bmrfs_pkg::OP_QUERY,  16'd4353,  16'hFFFE);
      send_item(bmrfs_pkg::OP_QUERY,  16'd300,   16'd200);
      send_item(bmrfs_pkg::OP_QUERY,  16'hFFFF,  16'hFFFE);
   endtask

   // The unused opcode must leave the bitmap untouched and answer nothing.
   task automatic test_unused_opcode();
      send_item(OP_UNUSED,            16'd5,    16'd5);
      send_item(OP_UNUSED,            16'hFFFF, 16'hFFFF);
      send_item(bmrfs_pkg::OP_QUERY,  16'd2,    16'd62);
   endtask

   // A clear empties everything; a value inserted afterwards is seen alone.
   task automatic test_clear_all();
      send_item(bmrfs_pkg::OP_CLEAR,  16'hFFFF,  16'hFFFF);
      send_item(bmrfs_pkg::OP_QUERY,  16'd0,     16'hFFFF);
      send_item(bmrfs_pkg::OP_INSERT, 16'd40000, 16'd0);
      send_item(bmrfs_pkg::OP_QUERY,  16'd1,     16'hFFFF);
   endtask

   // Hold the response side off for a long stretch while beats keep coming.
   task automatic test_output_backpressure();
      logic [bmrfs_pkg::VALUE_W-1:0] low_v;
      logic [bmrfs_pkg::VALUE_W-1:0] high_v;
      send_idle_pct = 0;
      stall_pct     = 0;
      hot_base      = $urandom_range(TOP_VALUE - 2048);
      hold_asked++;
      repeat (40) begin
         if ($urandom_range(3) == 0) begin
            send_item(bmrfs_pkg::OP_INSERT, pick_insert_value(),
                      bmrfs_pkg::VALUE_W'($urandom));
         end else begin
            pick_query(low_v, high_v);
            send_item(bmrfs_pkg::OP_QUERY, low_v, high_v);
         end
      end
   endtask

   // Random mix of operations under one idling setting.
   task automatic test_random_phase(input int unsigned count, input int unsigned idle_pct,
                                    input int unsigned stall_in);
      int unsigned                    done_items;
      int unsigned                    pick;
      logic [bmrfs_pkg::OPCODE_W-1:0] op;
      logic [bmrfs_pkg::VALUE_W-1:0]  low_v;
      logic [bmrfs_pkg::VALUE_W-1:0]  high_v;
      done_items    = 0;
      send_idle_pct = idle_pct;
      stall_pct     = stall_in;
      hot_base      = $urandom_range(TOP_VALUE - 2048);
      while (done_items < count) begin
         pick = $urandom_range(999);
         if (pick < 480) begin
            op     = bmrfs_pkg::OP_INSERT;
            low_v  = pick_insert_value();
            high_v = bmrfs_pkg::VALUE_W'($urandom);
         end else if (pick < 940) begin
            op = bmrfs_pkg::OP_QUERY;
            pick_query(low_v, high_v);
         end else if (pick < 950) begin
            op     = bmrfs_pkg::OP_CLEAR;
            low_v  = bmrfs_pkg::VALUE_W'($urandom);
            high_v = bmrfs_pkg::VALUE_W'($urandom);
         end else begin
            op     = OP_UNUSED;
            low_v  = bmrfs_pkg::VALUE_W'($urandom);
            high_v = bmrfs_pkg::VALUE_W'($urandom);
         end
         send_item(op, low_v, high_v);
         if (op != OP_UNUSED) done_items++;
      end
   endtask

   // Response-side ready: random stalls, or a long hold when one is asked for.
   always @(posedge clock) begin : rsp_pacing
      if (hold_left == 0 && hold_done != hold_asked) begin
         hold_done = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Compare each response beat with the oldest owed answer.
   always @(posedge clock) begin : answer_check
      query_answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_answers.size() == 0) begin
            $error("unexpected response beat: found %0d first_value %0d",
                   rsp_found, rsp_first_value);
            fail_count++;
         end else begin
            want = owed_answers.pop_front();
            if (rsp_found !== want.found) begin
               $error("found mismatch: expected %0d, actual %0d", want.found, rsp_found);
               fail_count++;
            end
            if (rsp_first_value !== want.first_value) begin
               $error("first_value mismatch: expected %0d, actual %0d",
                      want.first_value, rsp_first_value);
               fail_count++;
            end
         end
      end
   end

   // Give up on a hang.
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bitmap_range_first_set_top test failed");
         $finish;
      end
   end

   initial begin
      foreach (bitmap_words[i]) bitmap_words[i] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_unused_opcode();
      test_clear_all();
      test_output_backpressure();
      test_random_phase(330, 0, 0);
      test_random_phase(330, 74, 0);
      test_random_phase(330, 0, 74);
      test_random_phase(330, 26, 26);

      // Let every owed answer drain, then watch for stray beats.
      req_valid <= 1'b0;
      stall_pct = 0;
      while (owed_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && owed_answers.size() == 0)
         $display("bitmap_range_first_set_top test passed");
      else
         $display("bitmap_range_first_set_top test failed");
      $finish;
   end

endmodule
